>>> rtl/lla_pkg.sv
// Package for the light level accumulator: widths, light kind codes, queue entry type
// and the inner level saturation helper. No dependencies; every other file imports it.

package lla_pkg;

   // Ceiling of the level range. Internal level registers are LEVEL_W wide, which covers
   // any ceiling up to 255.
   localparam int unsigned MAX_LEVEL = 63;
   localparam int unsigned LEVEL_W   = 8;
   localparam int unsigned OUT_W     = 6;
   localparam int unsigned MIN_W     = 6;

   localparam int unsigned COORD_W   = 16;
   localparam int unsigned SHIFT_W   = 3;
   localparam int unsigned DIST_W    = COORD_W + (1 << SHIFT_W) - 1;
   localparam int unsigned RADIUS_W  = 16;
   localparam int unsigned SCALE_W   = 23;
   localparam int unsigned FRAC_W    = 16;
   localparam int unsigned INNER_W   = 16;
   localparam int unsigned PROD_W    = RADIUS_W + SCALE_W;
   localparam int unsigned GAIN_W    = PROD_W - FRAC_W;

   localparam int unsigned QDEPTH    = 4;
   localparam int unsigned QPTR_W    = $clog2(QDEPTH);
   localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

   localparam logic [LEVEL_W-1:0] MAX_LEVEL_V = LEVEL_W'(MAX_LEVEL);

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_NONE  = 2'd0;
   localparam kind_type KIND_LIGHT = 2'd1;
   localparam kind_type KIND_SOLID = 2'd2;

   typedef struct packed {
      kind_type              kind;
      logic [RADIUS_W-1:0]   reach;
      logic [SCALE_W-1:0]    scale;
      logic [LEVEL_W-1:0]    inner;
      logic                  last;
   } entry_type;

   function automatic logic [LEVEL_W-1:0] sat_inner(input logic [INNER_W-1:0] value);
      logic [LEVEL_W-1:0] result;
      if (value > INNER_W'(MAX_LEVEL)) begin
         result = MAX_LEVEL_V;
      end else begin
         result = LEVEL_W'(value);
      end
      return result;
   endfunction

endpackage

>>> rtl/lla_req_if.sv
// Request channel of the light level accumulator: valid/ready and one light.
// Depends on lla_pkg for the field widths.

interface lla_req_if;
   import lla_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [COORD_W-1:0]    block_x;
   logic signed [COORD_W-1:0]    block_y;
   logic signed [COORD_W-1:0]    light_x;
   logic signed [COORD_W-1:0]    light_y;
   logic [SHIFT_W-1:0]           shift_x;
   logic [SHIFT_W-1:0]           shift_y;
   logic [RADIUS_W-1:0]          cutoff_radius;
   logic [SCALE_W-1:0]           falloff_scale;
   logic                         is_solid;
   logic [INNER_W-1:0]           inner_level;
   logic                         has_light;
   logic                         last_light;

   modport source (
      output valid, block_x, block_y, light_x, light_y, shift_x, shift_y,
             cutoff_radius, falloff_scale, is_solid, inner_level, has_light, last_light,
      input  ready
   );

   modport sink (
      input  valid, block_x, block_y, light_x, light_y, shift_x, shift_y,
             cutoff_radius, falloff_scale, is_solid, inner_level, has_light, last_light,
      output ready
   );

endinterface

>>> rtl/lla_rsp_if.sv
// Response channel of the light level accumulator: valid/ready and the block level.
// Depends on lla_pkg for the field width.

interface lla_rsp_if;
   import lla_pkg::*;

   logic               valid;
   logic               ready;
   logic [OUT_W-1:0]   light_level;

   modport source (
      output valid, light_level,
      input  ready
   );

   modport sink (
      input  valid, light_level,
      output ready
   );

endinterface

>>> rtl/light_level_accumulator_unit.sv
// Top level of the light level accumulator: min_level register, front end, queue
// and back end. Depends on lla_pkg, lla_req_if, lla_rsp_if and the lla_* modules.
//
//   channel    direction  handshake        carries
//   req_chan   in         valid/ready      one light of a block's patch, last mark
//   rsp_chan   out        valid/ready      light_level of the block, on its last light
//   csr_*      in         csr_we           min_level (ambient minimum)
//
// One request is taken every clock while the response side keeps up; the rate is set
// by the level accumulate loop in the back end.
// The last light passes front stage 1, front stage 2, the queue, b1 and the response register.
// Reset is synchronous: it empties the pipeline and queue, closes any open patch and
// clears min_level to zero.
// A stalled response holds the back end; the queue and front stages keep taking
// requests until they fill, then req_chan.ready drops.

module light_level_accumulator_unit (
   input  logic                      clock,
   input  logic                      reset,
   lla_req_if.sink                   req_chan,
   lla_rsp_if.source                 rsp_chan,
   input  logic                      csr_we,
   input  logic [lla_pkg::MIN_W-1:0] csr_wdata
);
   import lla_pkg::*;

   logic [MIN_W-1:0]  min_level_ff, min_level_in;

   logic              fq_valid, fq_ready;
   entry_type         fq_entry;
   logic              bq_valid, bq_ready;
   entry_type         bq_entry;

   // ambient minimum; sampled by the back end when a patch opens
   assign min_level_in = csr_we ? csr_wdata : min_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_level_ff <= '0;
      end else begin
         min_level_ff <= min_level_in;
      end
   end

   // classify lights and compute distances
   lla_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .fq_valid (fq_valid),
      .fq_ready (fq_ready),
      .fq_entry (fq_entry)
   );

   // decouple front and back
   lla_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_entry (fq_entry),
      .pop_valid  (bq_valid),
      .pop_ready  (bq_ready),
      .pop_entry  (bq_entry)
   );

   // multiply, accumulate per patch and drive the response
   lla_back u_back (
      .clock     (clock),
      .reset     (reset),
      .min_level (min_level_ff),
      .q_valid   (bq_valid),
      .q_ready   (bq_ready),
      .q_entry   (bq_entry),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> rtl/lla_front.sv
// Front end of the light level accumulator: takes requests, computes the approximate
// distance in two stages and classifies each light. Depends on lla_pkg and lla_req_if.

module lla_front (
   input  logic                clock,
   input  logic                reset,
   lla_req_if.sink             req_chan,
   output logic                fq_valid,
   input  logic                fq_ready,
   output lla_pkg::entry_type  fq_entry
);
   import lla_pkg::*;

   // stage 1: shifted absolute distances
   logic                     s1_valid_ff, s1_valid_in;
   logic [DIST_W-1:0]        s1_dx_ff, s1_dy_ff;
   logic [RADIUS_W-1:0]      s1_outer_ff;
   logic [SCALE_W-1:0]       s1_scale_ff;
   logic                     s1_solid_ff;
   logic [LEVEL_W-1:0]       s1_inner_ff;
   logic                     s1_has_ff;
   logic                     s1_last_ff;

   // stage 2: classified entry
   logic                     s2_valid_ff, s2_valid_in;
   entry_type                s2_entry_ff, s2_entry_in;

   logic                     s1_ready, s2_ready;
   logic                     req_take;
   logic signed [COORD_W:0]  diff_x, diff_y;
   logic [COORD_W-1:0]       abs_x, abs_y;
   logic [DIST_W-1:0]        dist_x, dist_y;
   logic [DIST_W-1:0]        near_d;
   logic [DIST_W:0]          radius;
   logic                     in_reach;

   assign s2_ready       = !s2_valid_ff || fq_ready;
   assign s1_ready       = !s1_valid_ff || s2_ready;
   assign req_chan.ready = s1_ready;
   assign req_take       = req_chan.valid && s1_ready;

   always_comb begin
      diff_x = {req_chan.light_x[COORD_W-1], req_chan.light_x}
             - {req_chan.block_x[COORD_W-1], req_chan.block_x};
      diff_y = {req_chan.light_y[COORD_W-1], req_chan.light_y}
             - {req_chan.block_y[COORD_W-1], req_chan.block_y};
      abs_x  = diff_x[COORD_W] ? COORD_W'(-diff_x) : COORD_W'(diff_x);
      abs_y  = diff_y[COORD_W] ? COORD_W'(-diff_y) : COORD_W'(diff_y);
      dist_x = DIST_W'(abs_x) << req_chan.shift_x;
      dist_y = DIST_W'(abs_y) << req_chan.shift_y;
   end

   assign s1_valid_in = s1_ready ? req_chan.valid : s1_valid_ff;

   // stage 2: dx + dy - min/2, compare against the outer radius
   always_comb begin
      near_d   = (s1_dx_ff < s1_dy_ff) ? s1_dx_ff : s1_dy_ff;
      radius   = {1'b0, s1_dx_ff} + {1'b0, s1_dy_ff} - {2'b00, near_d[DIST_W-1:1]};
      in_reach = radius < (DIST_W + 1)'(s1_outer_ff);

      s2_entry_in.reach = s1_outer_ff - radius[RADIUS_W-1:0];
      s2_entry_in.scale = s1_scale_ff;
      s2_entry_in.inner = s1_inner_ff;
      s2_entry_in.last  = s1_last_ff;
      if (!s1_has_ff) begin
         s2_entry_in.kind = KIND_NONE;
      end else if (s1_solid_ff) begin
         s2_entry_in.kind = KIND_SOLID;
      end else if (in_reach) begin
         s2_entry_in.kind = KIND_LIGHT;
      end else begin
         s2_entry_in.kind = KIND_NONE;
      end
   end

   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_dx_ff    <= dist_x;
         s1_dy_ff    <= dist_y;
         s1_outer_ff <= req_chan.cutoff_radius;
         s1_scale_ff <= req_chan.falloff_scale;
         s1_solid_ff <= req_chan.is_solid;
         s1_inner_ff <= sat_inner(req_chan.inner_level);
         s1_has_ff   <= req_chan.has_light;
         s1_last_ff  <= req_chan.last_light;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_entry_ff <= s2_entry_in;
      end
   end

   assign fq_valid = s2_valid_ff;
   assign fq_entry = s2_entry_ff;

endmodule

>>> rtl/lla_queue.sv
// Short queue between the front and back ends of the light level accumulator.
// Depends on lla_pkg for the entry type and depth.

module lla_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  lla_pkg::entry_type  push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output lla_pkg::entry_type  pop_entry
);
   import lla_pkg::*;

   entry_type            slots_ff [QDEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;
   logic                 push, pop;

   assign push_ready = count_ff < QCNT_W'(QDEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue count beyond depth");

   a_count_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - QCNT_W'(1)))
      else $error("queue count did not drop on a lone pop");

   a_count_fill: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("queue count did not rise on a lone push");
`endif

endmodule

>>> rtl/lla_back.sv
// Back end of the light level accumulator: falloff multiply, patch accumulation and
// the response register. Depends on lla_pkg and lla_rsp_if.

module lla_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [lla_pkg::MIN_W-1:0] min_level,
   input  logic                   q_valid,
   output logic                   q_ready,
   input  lla_pkg::entry_type     q_entry,
   lla_rsp_if.source              rsp_chan
);
   import lla_pkg::*;

   // multiply stage
   logic                  b1_valid_ff, b1_valid_in;
   kind_type              b1_kind_ff;
   logic [LEVEL_W-1:0]    b1_inner_ff;
   logic                  b1_last_ff;
   logic [PROD_W-1:0]     b1_prod_ff;

   // patch state
   logic                  in_patch_ff, in_patch_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic                  solid_seen_ff, solid_seen_in;
   logic [LEVEL_W-1:0]    solid_value_ff, solid_value_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]      rsp_level_ff, rsp_level_in;

   logic                  out_free, b1_ready, retire;
   logic [GAIN_W-1:0]     gain;
   logic [LEVEL_W-1:0]    gain_sat, min_ext, base_level, final_level;
   logic [LEVEL_W:0]      sum;
   logic                  base_solid;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign b1_ready = !b1_valid_ff || out_free;
   assign q_ready  = b1_ready;
   assign retire   = b1_valid_ff && out_free;

   assign b1_valid_in = b1_ready ? q_valid : b1_valid_ff;

   always_comb begin
      gain     = b1_prod_ff[PROD_W-1:FRAC_W];
      gain_sat = (gain > GAIN_W'(MAX_LEVEL)) ? MAX_LEVEL_V : LEVEL_W'(gain);
      min_ext  = LEVEL_W'(min_level);

      // open a patch from the ambient minimum
      if (in_patch_ff) begin
         base_level = level_ff;
         base_solid = solid_seen_ff;
      end else begin
         base_level = (min_ext > MAX_LEVEL_V) ? MAX_LEVEL_V : min_ext;
         base_solid = 1'b0;
      end

      sum            = {1'b0, base_level} + {1'b0, gain_sat};
      level_in       = base_level;
      solid_seen_in  = base_solid;
      solid_value_in = solid_value_ff;
      if (!base_solid) begin
         case (b1_kind_ff)
            KIND_LIGHT: level_in = (sum > (LEVEL_W + 1)'(MAX_LEVEL)) ? MAX_LEVEL_V
                                                                    : sum[LEVEL_W-1:0];
            KIND_SOLID: begin
               solid_seen_in  = 1'b1;
               solid_value_in = b1_inner_ff;
            end
            default: ;
         endcase
      end
      final_level = solid_seen_in ? solid_value_in : level_in;

      // close the patch on its last light
      if (b1_last_ff) begin
         in_patch_in   = 1'b0;
         solid_seen_in = 1'b0;
      end else begin
         in_patch_in   = 1'b1;
      end

      rsp_level_in = final_level[OUT_W-1:0];
      if (retire && b1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff    <= 1'b0;
         in_patch_ff    <= 1'b0;
         level_ff       <= '0;
         solid_seen_ff  <= 1'b0;
         solid_value_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         b1_valid_ff <= b1_valid_in;
         if (retire) begin
            in_patch_ff    <= in_patch_in;
            level_ff       <= level_in;
            solid_seen_ff  <= solid_seen_in;
            solid_value_ff <= solid_value_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_valid && b1_ready) begin
         b1_kind_ff  <= q_entry.kind;
         b1_inner_ff <= q_entry.inner;
         b1_last_ff  <= q_entry.last;
         b1_prod_ff  <= PROD_W'(q_entry.reach) * PROD_W'(q_entry.scale);
      end
      if (retire && b1_last_ff) begin
         rsp_level_ff <= rsp_level_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.light_level = rsp_level_ff;

`ifndef SYNTHESIS
   a_solid_in_patch: assert property (@(posedge clock) disable iff (reset)
      !in_patch_ff |-> !solid_seen_ff)
      else $error("solid mark outlived its patch");

   a_level_ceiling: assert property (@(posedge clock) disable iff (reset)
      (level_ff <= MAX_LEVEL_V) && (solid_value_ff <= MAX_LEVEL_V))
      else $error("level above ceiling");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> (rsp_valid_ff && $stable(rsp_level_ff)))
      else $error("stalled response changed");
`endif

endmodule
